[hw/rtl/seq_pkg.sv]
// ----------------------------------------------------------------------------
// seq_pkg
// Shared types and constants for the sorted expiry queue: operation codes,
// controller states and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package seq_pkg;

	localparam int SEQ_DEPTH        = 16;
	localparam int SEQ_TIME_BITS    = 32;
	localparam int SEQ_PAYLOAD_BITS = 32;
	localparam int MODE_BITS        = 3;

	localparam logic [MODE_BITS-1:0] MODE_ORDERED = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_HEAD    = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_REMOVE  = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_VIEW    = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_CLEAR   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RIPPLE,
		ST_TAIL,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic load;       // latch the new transaction
		logic load_head;  // insert goes to the head, no ordering
		logic load_tail;  // first read targets the tail entry
		logic scan;
		logic ripple;
		logic tail;
		logic pop;
		logic clear;
		logic reject;
		logic emit;
	} seq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic found;
		logic at_end;
		logic last_move;
	} seq_sts_t;

endpackage

[hw/rtl/seq_ram.sv]
// ----------------------------------------------------------------------------
// seq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module seq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hw/rtl/seq_ctrl.sv]
// ----------------------------------------------------------------------------
// seq_ctrl
// Controller for the sorted expiry queue: decodes the mode of each transaction,
// steps the datapath through scan, ripple or tail read, and owns the output valid.
// ----------------------------------------------------------------------------
module seq_ctrl
	import seq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [MODE_BITS-1:0] mode,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  seq_sts_t             sts,
	output seq_cmd_t             cmd
);

	seq_state_t state_q, state_d;
	logic       pop_q;
	logic       out_valid_q;
	logic       is_insert;
	logic       is_tail_op;

	assign is_insert  = (mode == MODE_ORDERED) || (mode == MODE_HEAD);
	assign is_tail_op = (mode == MODE_REMOVE) || (mode == MODE_VIEW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pop_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				pop_q <= (mode == MODE_REMOVE);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.load_head = (mode == MODE_HEAD);
					cmd.load_tail = is_tail_op;
					priority if (is_insert) begin
						if (sts.full) begin
							cmd.reject = 1'b1;
							state_d    = ST_EMIT;
						end else begin
							state_d = ST_SCAN;
						end
					end else if (is_tail_op) begin
						if (sts.empty) begin
							cmd.reject = 1'b1;
							state_d    = ST_EMIT;
						end else begin
							state_d = ST_TAIL;
						end
					end else if (mode == MODE_CLEAR) begin
						cmd.clear = 1'b1;
						state_d   = ST_EMIT;
					end else begin
						cmd.reject = 1'b1;
						state_d    = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					state_d = sts.at_end ? ST_EMIT : ST_RIPPLE;
				end
			end
			ST_RIPPLE: begin
				cmd.ripple = 1'b1;
				if (sts.last_move) begin
					state_d = ST_EMIT;
				end
			end
			ST_TAIL: begin
				cmd.tail = 1'b1;
				cmd.pop  = pop_q;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/seq_dp.sv]
// ----------------------------------------------------------------------------
// seq_dp
// Datapath of the sorted expiry queue: entry RAM, scan index, carry register for
// the ripple shift toward the tail, occupancy count and the result registers.
// ----------------------------------------------------------------------------
module seq_dp
	import seq_pkg::*;
#(
	parameter int DEPTH        = SEQ_DEPTH,
	parameter int TIME_BITS    = SEQ_TIME_BITS,
	parameter int PAYLOAD_BITS = SEQ_PAYLOAD_BITS,
	localparam int CW          = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  seq_cmd_t                cmd,
	output seq_sts_t                sts,
	input  logic [TIME_BITS-1:0]    expiry_time,
	input  logic [PAYLOAD_BITS-1:0] entry_payload,
	output logic                    ok,
	output logic [TIME_BITS-1:0]    tail_time,
	output logic [PAYLOAD_BITS-1:0] tail_payload,
	output logic [CW-1:0]           count
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = TIME_BITS + PAYLOAD_BITS;

	logic [CW-1:0]           occ_q;
	logic [CW-1:0]           idx_q;
	logic [TIME_BITS-1:0]    time_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic                    head_q;
	logic [EW-1:0]           carry_q;
	logic                    pend_ok_q;
	logic [TIME_BITS-1:0]    pend_time_q;
	logic [PAYLOAD_BITS-1:0] pend_payload_q;
	logic                    res_ok_q;
	logic [TIME_BITS-1:0]    res_time_q;
	logic [PAYLOAD_BITS-1:0] res_payload_q;
	logic [CW-1:0]           res_count_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;
	logic [AW-1:0]           rd_addr;
	logic [EW-1:0]           rd_data;
	logic [TIME_BITS-1:0]    rd_time;
	logic [PAYLOAD_BITS-1:0] rd_payload;
	logic [CW-1:0]           idx_inc;
	logic [CW-1:0]           idx_inc2;
	logic [CW-1:0]           occ_dec;

	assign rd_time    = rd_data[PAYLOAD_BITS +: TIME_BITS];
	assign rd_payload = rd_data[PAYLOAD_BITS-1:0];
	assign idx_inc    = idx_q + CW'(1);
	assign idx_inc2   = idx_q + CW'(2);
	assign occ_dec    = occ_q - CW'(1);

	assign sts.empty     = (occ_q == '0);
	assign sts.full      = (occ_q == CW'(DEPTH));
	assign sts.at_end    = (idx_q == occ_q);
	// found on a head insert, at the end of the list, or when slot idx_q is the first one whose time is below the new one
	assign sts.found     = head_q || sts.at_end || (rd_time < time_q);
	assign sts.last_move = (idx_inc == occ_q);

	// scan reads one slot ahead; ripple reads two ahead of the carry position
	always_comb begin
		priority if (cmd.load) begin
			rd_addr = cmd.load_tail ? occ_dec[AW-1:0] : '0;
		end else if (cmd.ripple) begin
			rd_addr = idx_inc2[AW-1:0];
		end else begin
			rd_addr = idx_inc[AW-1:0];
		end
	end

	assign wr_en   = (cmd.scan && sts.found) || cmd.ripple;
	assign wr_addr = cmd.ripple ? idx_inc[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.ripple ? carry_q : {time_q, payload_q};

	seq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if (cmd.clear) begin
				occ_q <= '0;
			end else if ((cmd.scan && sts.found && sts.at_end) ||
			             (cmd.ripple && sts.last_move)) begin
				occ_q <= occ_q + CW'(1);
			end else if (cmd.tail && cmd.pop) begin
				occ_q <= occ_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q    <= expiry_time;
			payload_q <= entry_payload;
			head_q    <= cmd.load_head;
			idx_q     <= '0;
		end
		if (cmd.scan) begin
			if (!sts.found) begin
				idx_q <= idx_inc;
			end else begin
				carry_q <= rd_data;
			end
		end
		if (cmd.ripple) begin
			carry_q <= rd_data;
			idx_q   <= idx_inc;
		end
		if ((cmd.scan && sts.found && sts.at_end) || (cmd.ripple && sts.last_move) ||
		    cmd.clear) begin
			pend_ok_q      <= 1'b1;
			pend_time_q    <= '0;
			pend_payload_q <= '0;
		end else if (cmd.tail) begin
			pend_ok_q      <= 1'b1;
			pend_time_q    <= rd_time;
			pend_payload_q <= rd_payload;
		end else if (cmd.reject) begin
			pend_ok_q      <= 1'b0;
			pend_time_q    <= '0;
			pend_payload_q <= '0;
		end
		if (cmd.emit) begin
			res_ok_q      <= pend_ok_q;
			res_time_q    <= pend_time_q;
			res_payload_q <= pend_payload_q;
			res_count_q   <= occ_q;
		end
	end

	assign ok           = res_ok_q;
	assign tail_time    = res_time_q;
	assign tail_payload = res_payload_q;
	assign count        = res_count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (idx_q <= occ_q) && !sts.full)
		else $error("scan index past occupancy or scan on a full queue");

	a_ripple_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ripple |-> idx_inc <= occ_q)
		else $error("ripple write past occupancy");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> occ_q == '0)
		else $error("clear did not empty the queue");

endmodule

[hw/rtl/sorted_expiry_queue.sv]
// ----------------------------------------------------------------------------
// sorted_expiry_queue
// Bounded queue of expiry time and payload entries, ordered largest time first.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. The entry RAM has one read and one write
// port, so the scan for the insert point of an ordered or head insert and the
// ripple of later entries toward the tail move one slot per cycle. Remove and view
// read the tail entry from the registered RAM port. Clear, rejects and unknown
// modes go straight from accept to the result stage. The next transaction is taken
// while a finished result still waits in the output register. Modes: 0 ordered
// insert (after all entries with an equal or larger time), 1 head insert, 2 remove
// tail, 3 view tail, 4 clear.
module sorted_expiry_queue
	import seq_pkg::*;
#(
	parameter int DEPTH        = SEQ_DEPTH,
	parameter int TIME_BITS    = SEQ_TIME_BITS,
	parameter int PAYLOAD_BITS = SEQ_PAYLOAD_BITS,
	localparam int CW          = $clog2(DEPTH + 1),
	localparam int IN_W        = MODE_BITS + TIME_BITS + PAYLOAD_BITS,
	localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W       = 1 + TIME_BITS + PAYLOAD_BITS + CW,
	localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_TW-1:0]  s_axis_tdata,   // mode, expiry_time, entry_payload
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_TW-1:0] m_axis_tdata    // ok, tail_time, tail_payload, count
);

	seq_cmd_t                cmd;
	seq_sts_t                sts;
	logic [MODE_BITS-1:0]    mode;
	logic [TIME_BITS-1:0]    expiry_time;
	logic [PAYLOAD_BITS-1:0] entry_payload;
	logic                    ok;
	logic [TIME_BITS-1:0]    tail_time;
	logic [PAYLOAD_BITS-1:0] tail_payload;
	logic [CW-1:0]           count;

	assign mode          = s_axis_tdata[MODE_BITS-1:0];
	assign expiry_time   = s_axis_tdata[MODE_BITS +: TIME_BITS];
	assign entry_payload = s_axis_tdata[MODE_BITS+TIME_BITS +: PAYLOAD_BITS];

	seq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.mode      (mode),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd)
	);

	seq_dp #(
		.DEPTH        (DEPTH),
		.TIME_BITS    (TIME_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.expiry_time   (expiry_time),
		.entry_payload (entry_payload),
		.ok            (ok),
		.tail_time     (tail_time),
		.tail_payload  (tail_payload),
		.count         (count)
	);

	assign m_axis_tdata = OUT_TW'({count, tail_payload, tail_time, ok});

endmodule

[bench/sorted_expiry_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_expiry_queue_test
// Self-checking bench for the sorted expiry queue. A scoreboard keeps its own
// copy of the ordered entry list, predicts the status of every transaction and
// compares each output transaction field by field. Stimulus is a directed
// opening followed by random blocks biased toward filling or draining, with
// random idle on both sides and long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module sorted_expiry_queue_test;
	import seq_pkg::*;

	localparam int CW        = $clog2(SEQ_DEPTH + 1);
	localparam int IN_W      = MODE_BITS + SEQ_TIME_BITS + SEQ_PAYLOAD_BITS;
	localparam int IN_TW     = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W     = 1 + SEQ_TIME_BITS + SEQ_PAYLOAD_BITS + CW;
	localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8;
	localparam int RANDOM_OPS = 1900;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic                        ok;
		logic [SEQ_TIME_BITS-1:0]    tail_time;
		logic [SEQ_PAYLOAD_BITS-1:0] tail_payload;
		logic [CW-1:0]               count;
	} queue_status_t;

	class expiry_scoreboard;
		logic [SEQ_TIME_BITS-1:0]    slot_time [SEQ_DEPTH];
		logic [SEQ_PAYLOAD_BITS-1:0] slot_payload [SEQ_DEPTH];
		int unsigned                 held;
		queue_status_t               pending_status [$];
		int mismatches, results_checked;
		int inserts, full_rejects, tail_reads, empty_reads, clears, unknown_ops, peak;

		function new();
			held = 0;
			mismatches = 0;
			results_checked = 0;
			inserts = 0;
			full_rejects = 0;
			tail_reads = 0;
			empty_reads = 0;
			clears = 0;
			unknown_ops = 0;
			peak = 0;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
		endtask

		// predict the status of one accepted input transaction
		function void note_operation(logic [MODE_BITS-1:0] op, logic [SEQ_TIME_BITS-1:0] t,
				logic [SEQ_PAYLOAD_BITS-1:0] p);
			queue_status_t st;
			int unsigned pos;
			st = '0;
			case (op)
				MODE_ORDERED, MODE_HEAD: begin
					if (held < SEQ_DEPTH) begin
						pos = 0;
						// after every entry with an equal or larger time
						if (op == MODE_ORDERED)
							while (pos < held && slot_time[pos] >= t)
								pos++;
						for (int unsigned i = held; i > pos; i--) begin
							slot_time[i] = slot_time[i - 1];
							slot_payload[i] = slot_payload[i - 1];
						end
						slot_time[pos] = t;
						slot_payload[pos] = p;
						held++;
						st.ok = 1'b1;
						inserts++;
					end else begin
						full_rejects++;
					end
				end
				MODE_REMOVE, MODE_VIEW: begin
					if (held > 0) begin
						st.tail_time = slot_time[held - 1];
						st.tail_payload = slot_payload[held - 1];
						if (op == MODE_REMOVE)
							held--;
						st.ok = 1'b1;
						tail_reads++;
					end else begin
						empty_reads++;
					end
				end
				MODE_CLEAR: begin
					held = 0;
					st.ok = 1'b1;
					clears++;
				end
				default: unknown_ops++;
			endcase
			st.count = CW'(held);
			if (held > peak)
				peak = held;
			pending_status.push_back(st);
		endfunction

		task check_result(logic [OUT_TW-1:0] data);
			queue_status_t got, want;
			got.ok = data[0];
			got.tail_time = data[SEQ_TIME_BITS:1];
			got.tail_payload = data[SEQ_TIME_BITS+SEQ_PAYLOAD_BITS:SEQ_TIME_BITS+1];
			got.count = data[OUT_W-1:OUT_W-CW];
			results_checked++;
			if (pending_status.size() == 0) begin
				report_mismatch($sformatf("unexpected transaction %h", data));
			end else begin
				want = pending_status.pop_front();
				if (got.ok !== want.ok)
					report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
				if (got.tail_time !== want.tail_time)
					report_mismatch($sformatf("tail_time got %h want %h",
						got.tail_time, want.tail_time));
				if (got.tail_payload !== want.tail_payload)
					report_mismatch($sformatf("tail_payload got %h want %h",
						got.tail_payload, want.tail_payload));
				if (got.count !== want.count)
					report_mismatch($sformatf("count got %0d want %0d",
						got.count, want.count));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_TW-1:0]  s_axis_tdata;   // mode, expiry_time, entry_payload
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_TW-1:0] m_axis_tdata;   // ok, tail_time, tail_payload, count

	expiry_scoreboard sb;
	bit               steady_phase;
	int               cycle_count;
	int               hold_offs;

	sorted_expiry_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_status.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_phase || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// dense small values make equal times common
	function automatic logic [SEQ_TIME_BITS-1:0] pick_time();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(0, 7);
		if (r == 4)
			return '0;
		if (r == 5)
			return '1;
		return $urandom;
	endfunction

	task automatic send_op(logic [MODE_BITS-1:0] op, logic [SEQ_TIME_BITS-1:0] t,
			logic [SEQ_PAYLOAD_BITS-1:0] p);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TW-IN_W){1'b0}}, p, t, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_operation(op, t, p);
	endtask

	// picks a mode according to the bias of the current block
	function automatic logic [MODE_BITS-1:0] pick_mode(int bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return MODE_CLEAR;
		if (r < 4)
			return MODE_BITS'($urandom_range(MODE_CLEAR + 1, 7));
		r = $urandom_range(0, 99);
		case (bias)
			0: begin
				if (r < 55) return MODE_ORDERED;
				if (r < 75) return MODE_HEAD;
				if (r < 90) return MODE_REMOVE;
				return MODE_VIEW;
			end
			1: begin
				if (r < 15) return MODE_ORDERED;
				if (r < 22) return MODE_HEAD;
				if (r < 80) return MODE_REMOVE;
				return MODE_VIEW;
			end
			default: begin
				if (r < 35) return MODE_ORDERED;
				if (r < 48) return MODE_HEAD;
				if (r < 80) return MODE_REMOVE;
				return MODE_VIEW;
			end
		endcase
	endfunction

	// output side: random stalls after each transaction, two long hold-offs
	initial begin
		int stall;
		int results_seen;
		stall = 0;
		results_seen = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
				results_seen++;
				if (results_seen == 400 || results_seen == 1500) begin
					stall = 600;
					hold_offs++;
				end else begin
					stall = idle_gap();
				end
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int real_ops;
		int block_left;
		int bias;
		logic [MODE_BITS-1:0] op;
		sb = new();
		steady_phase = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty reads, extremes, ties, head insert, unknown modes,
		// fill to capacity, rejected inserts, clear
		send_op(MODE_VIEW, '1, '1);
		send_op(MODE_REMOVE, '1, '1);
		send_op(MODE_ORDERED, '0, '0);
		send_op(MODE_ORDERED, '1, '1);
		send_op(MODE_ORDERED, 32'd5, 32'd1);
		send_op(MODE_ORDERED, 32'd5, 32'd2);
		send_op(MODE_HEAD, '0, 32'hA5A5_5A5A);
		send_op(MODE_VIEW, '0, '0);
		send_op(MODE_REMOVE, '0, '0);
		send_op(3'd5, 32'd9, 32'd9);
		send_op(3'd6, '0, '0);
		send_op(3'd7, '1, '1);
		for (int k = 0; k < 12; k++)
			send_op((k % 3 == 0) ? MODE_HEAD : MODE_ORDERED,
				(k < 4) ? 32'd5 : pick_time(), $urandom);
		send_op(MODE_ORDERED, 32'd3, 32'h1234_5678);
		send_op(MODE_HEAD, '1, '1);
		send_op(MODE_CLEAR, '1, '1);

		// random blocks, each biased to fill, drain or mix
		real_ops = 0;
		block_left = 0;
		bias = 0;
		while (real_ops < RANDOM_OPS) begin
			if (block_left == 0) begin
				block_left = $urandom_range(10, 60);
				bias = $urandom_range(0, 2);
				steady_phase = ($urandom_range(0, 4) == 0);
			end
			op = pick_mode(bias);
			send_op(op, pick_time(), $urandom);
			if (op <= MODE_CLEAR)
				real_ops++;
			block_left--;
		end
		s_axis_tvalid <= 1'b0;
		steady_phase = 1'b0;

		while (sb.pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d inserts, %0d rejected as full, %0d tail reads, %0d on empty",
			sb.inserts, sb.full_rejects, sb.tail_reads, sb.empty_reads);
		$display("plus %0d clears, %0d unknown modes, peak fill %0d, %0d output hold-offs",
			sb.clears, sb.unknown_ops, sb.peak, hold_offs);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/seq_pkg.sv
hw/rtl/seq_ram.sv
hw/rtl/seq_ctrl.sv
hw/rtl/seq_dp.sv
hw/rtl/sorted_expiry_queue.sv
bench/sorted_expiry_queue_test.sv
